/* rtl/dq_current_pi_controller_defines.svh */
// Assertion macros shared by the dq current PI controller checkers.
// No dependencies; included by the checker file.
`ifndef DQ_CURRENT_PI_CONTROLLER_DEFINES_SVH
`define DQ_CURRENT_PI_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define DQPI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dqpi: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define DQPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dqpi: next-cycle check failed");

`endif

/* rtl/dqpi_pkg.sv */
// Package for the dq current PI controller: register indexes and fixed widths.
// No dependencies; used by dq_current_pi_controller.
package dqpi_pkg;

  // Fixed widths of the register fields
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 15;
  localparam int CFG_IDX_W = 3;

  // Fixed-point shifts: Q8.8 proportional gain, Q0.16 integral gain
  localparam int PROP_SHIFT = 8;
  localparam int INT_SHIFT  = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_D_PROP_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_PROP_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_INT_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Q_INT_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_D_INT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Q_INT_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_D_OUT_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_Q_OUT_LIMIT = 3'd7;

  // Reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd256;
  localparam logic [GAIN_W-1:0] INT_GAIN_RST  = 16'd0;
  localparam logic [LIM_W-1:0]  LIMIT_RST     = 15'h7FFF;

endpackage

/* rtl/dq_current_pi_controller.sv */
// Each request is processed in 6 steps per axis before its result is valid; a new request
// is taken only in idle, after the last step. The shared multiplier, adder and clamp are
// stepped through error, proportional, increment, sum, voltage and limit for d then q.
// A full output register stalls only the final step. Config writes are always accepted.
// Reset (rst_ni low, async): gains and limits to defaults, integrators to zero, idle.
module dq_current_pi_controller
  import dqpi_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [GAIN_W-1:0]            cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] d_request_i,
  input  logic signed [DATA_WIDTH-1:0] q_request_i,
  input  logic signed [DATA_WIDTH-1:0] d_measured_i,
  input  logic signed [DATA_WIDTH-1:0] q_measured_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] d_voltage_o,
  output logic signed [DATA_WIDTH-1:0] q_voltage_o
);

  localparam int D  = DATA_WIDTH;
  localparam int PW = D + GAIN_W + 2;                   // product width
  localparam int CW = ((D > LIM_W) ? D : LIM_W) + 1;    // clamp compare width

  localparam logic signed [D-1:0] SAT_MAX = {1'b0, {(D-1){1'b1}}};
  localparam logic signed [D-1:0] SAT_MIN = {1'b1, {(D-1){1'b0}}};

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERR  = 3'd1;
  localparam logic [2:0] ST_PROP = 3'd2;
  localparam logic [2:0] ST_INC  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_VOLT = 3'd5;
  localparam logic [2:0] ST_LIM  = 3'd6;

  // Saturate a wide signed value to the D-bit range
  function automatic logic signed [D-1:0] sat_d(input logic signed [PW-1:0] v);
    logic [PW-D:0] top;
    top = v[PW-1:D-1];
    if ((&top) || (~|top)) begin
      sat_d = v[D-1:0];
    end else if (v[PW-1]) begin
      sat_d = SAT_MIN;
    end else begin
      sat_d = SAT_MAX;
    end
  endfunction

  // Symmetric clamp to +/- lim
  function automatic logic signed [D-1:0] clamp_sym(input logic signed [D-1:0] v,
                                                   input logic [LIM_W-1:0] lim);
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] lx;
    logic signed [CW-1:0] nx;
    vx = {{(CW-D){v[D-1]}}, v};
    lx = {{(CW-LIM_W){1'b0}}, lim};
    nx = -lx;
    if (vx > lx) begin
      clamp_sym = lx[D-1:0];
    end else if (vx < nx) begin
      clamp_sym = nx[D-1:0];
    end else begin
      clamp_sym = v;
    end
  endfunction

  // Configuration registers
  logic [GAIN_W-1:0] d_pg_q, q_pg_q, d_ig_q, q_ig_q;
  logic [LIM_W-1:0]  d_il_q, q_il_q, d_ol_q, q_ol_q;

  // Control and datapath registers
  logic [2:0]            state_q;
  logic                  axis_q;      // 0: d axis, 1: q axis
  logic signed [D-1:0]   d_req_q, q_req_q, d_meas_q, q_meas_q;
  logic signed [D:0]     acc_q;
  logic signed [D-1:0]   prop_q, sum_q;
  logic signed [D-1:0]   d_int_q, q_int_q;
  logic signed [D-1:0]   vd_q;
  logic                  out_valid_q;
  logic signed [D-1:0]   d_volt_q, q_volt_q;

  // Per-axis operand selection
  logic signed [D-1:0]   req_sel, meas_sel, int_sel;
  logic [GAIN_W-1:0]     pg_sel, ig_sel;
  logic [LIM_W-1:0]      il_sel, ol_sel;

  // Shared units
  logic signed [D:0]     mul_a;
  logic [GAIN_W-1:0]     mul_b;
  logic signed [PW-1:0]  mul_p, prop_sh, inc_sh;
  logic signed [D:0]     add_a, add_b;
  logic signed [D+1:0]   add_ax, add_bx;
  logic                  add_sub;
  logic signed [D+1:0]   add_s;
  logic signed [PW-1:0]  add_x;
  logic signed [D-1:0]   add_sat;
  logic signed [D-1:0]   clamp_in, clamp_res;
  logic [LIM_W-1:0]      clamp_lim;

  logic in_fire, out_fire, out_free, out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_q & out_ready_i;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_load    = (state_q == ST_LIM) & axis_q & out_free;

  assign out_valid_o = out_valid_q;
  assign d_voltage_o = d_volt_q;
  assign q_voltage_o = q_volt_q;

  // Axis multiplexers
  assign req_sel  = axis_q ? q_req_q  : d_req_q;
  assign meas_sel = axis_q ? q_meas_q : d_meas_q;
  assign int_sel  = axis_q ? q_int_q  : d_int_q;
  assign pg_sel   = axis_q ? q_pg_q   : d_pg_q;
  assign ig_sel   = axis_q ? q_ig_q   : d_ig_q;
  assign il_sel   = axis_q ? q_il_q   : d_il_q;
  assign ol_sel   = axis_q ? q_ol_q   : d_ol_q;

  // Shared multiplier: error * Kp, then prop * Ki
  always_comb begin
    if (state_q == ST_INC) begin
      mul_a = {prop_q[D-1], prop_q};
      mul_b = ig_sel;
    end else begin
      mul_a = acc_q;
      mul_b = pg_sel;
    end
  end
  assign mul_p   = $signed({{(PW-D-1){mul_a[D]}}, mul_a}) *
                   $signed({{(PW-GAIN_W){1'b0}}, mul_b});
  assign prop_sh = mul_p >>> PROP_SHIFT;
  assign inc_sh  = mul_p >>> INT_SHIFT;

  // Shared adder: error, integrator sum, voltage sum
  always_comb begin
    add_sub = 1'b0;
    case (state_q)
      ST_ERR: begin
        add_a   = {req_sel[D-1], req_sel};
        add_b   = {meas_sel[D-1], meas_sel};
        add_sub = 1'b1;
      end
      ST_SUM: begin
        add_a = {int_sel[D-1], int_sel};
        add_b = acc_q;
      end
      default: begin
        add_a = {prop_q[D-1], prop_q};
        add_b = {sum_q[D-1], sum_q};
      end
    endcase
  end
  assign add_ax  = {add_a[D], add_a};
  assign add_bx  = {add_b[D], add_b};
  assign add_s   = add_sub ? (add_ax - add_bx) : (add_ax + add_bx);
  assign add_x   = {{(PW-D-2){add_s[D+1]}}, add_s};
  assign add_sat = sat_d(add_x);

  // Shared clamp: integrator limit, then output limit
  assign clamp_in  = (state_q == ST_VOLT) ? sum_q : acc_q[D-1:0];
  assign clamp_lim = (state_q == ST_VOLT) ? il_sel : ol_sel;
  assign clamp_res = clamp_sym(clamp_in, clamp_lim);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_pg_q <= PROP_GAIN_RST;
      q_pg_q <= PROP_GAIN_RST;
      d_ig_q <= INT_GAIN_RST;
      q_ig_q <= INT_GAIN_RST;
      d_il_q <= LIMIT_RST;
      q_il_q <= LIMIT_RST;
      d_ol_q <= LIMIT_RST;
      q_ol_q <= LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_D_PROP_GAIN: d_pg_q <= cfg_data_i;
        REG_Q_PROP_GAIN: q_pg_q <= cfg_data_i;
        REG_D_INT_GAIN:  d_ig_q <= cfg_data_i;
        REG_Q_INT_GAIN:  q_ig_q <= cfg_data_i;
        REG_D_INT_LIMIT: d_il_q <= cfg_data_i[LIM_W-1:0];
        REG_Q_INT_LIMIT: q_il_q <= cfg_data_i[LIM_W-1:0];
        REG_D_OUT_LIMIT: d_ol_q <= cfg_data_i[LIM_W-1:0];
        REG_Q_OUT_LIMIT: q_ol_q <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture (payload, no reset)
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      d_req_q  <= d_request_i;
      q_req_q  <= q_request_i;
      d_meas_q <= d_measured_i;
      q_meas_q <= q_measured_i;
    end
  end

  // Datapath working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_ERR:  acc_q  <= add_s[D:0];
      ST_PROP: prop_q <= sat_d(prop_sh);
      ST_INC:  acc_q  <= inc_sh[D:0];
      ST_SUM:  sum_q  <= add_sat;
      ST_VOLT: acc_q  <= {add_sat[D-1], add_sat};
      ST_LIM: begin
        if (!axis_q) begin
          vd_q <= clamp_res;
        end
      end
      default: ;
    endcase
  end

  // Sequencer, integrators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      d_int_q     <= '0;
      q_int_q     <= '0;
      out_valid_q <= 1'b0;
      d_volt_q    <= '0;
      q_volt_q    <= '0;
    end else begin
      // Output valid: set on a finished pair, else cleared once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_ERR;
            axis_q  <= 1'b0;
          end
        end
        ST_ERR:  state_q <= ST_PROP;
        ST_PROP: state_q <= ST_INC;
        ST_INC:  state_q <= ST_SUM;
        ST_SUM:  state_q <= ST_VOLT;
        ST_VOLT: begin
          if (axis_q) begin
            q_int_q <= clamp_res;
          end else begin
            d_int_q <= clamp_res;
          end
          state_q <= ST_LIM;
        end
        ST_LIM: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_ERR;
          end else if (out_free) begin
            d_volt_q <= vd_q;
            q_volt_q <= clamp_res;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/dqpi_checker.sv */
// Port-level checker for dq_current_pi_controller, bound to the top level.
// Depends on dq_current_pi_controller_defines.svh.
`include "dq_current_pi_controller_defines.svh"

module dqpi_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [DATA_WIDTH-1:0] d_voltage_o,
  input logic signed [DATA_WIDTH-1:0] q_voltage_o
);

  logic in_acc, out_stall;
  logic [2*DATA_WIDTH-1:0] volts;

  assign in_acc    = in_valid_i & in_ready_o;
  assign out_stall = out_valid_o & ~out_ready_i;
  assign volts     = {d_voltage_o, q_voltage_o};

  // A stalled result stays valid
  `DQPI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o)

  // A stalled result keeps its payload
  `DQPI_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(volts))

  // The sequencer is busy through the error and proportional steps after a request
  `DQPI_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_acc, !in_ready_o ##1 !in_ready_o)

  // A new result appears together with the return to idle
  `DQPI_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, $rose(out_valid_o), in_ready_o)

endmodule

bind dq_current_pi_controller dqpi_checker #(.DATA_WIDTH(DATA_WIDTH)) u_dqpi_checker (.*);
